FILE: sv/hpre_pkg.sv
// Package for the hazard pointer reclaim engine.
// Holds operation and result codes and the controller/datapath command and status types.
// No dependencies.
package hpre_pkg;

   localparam int OpWidth   = 3;
   localparam int TidWidth  = 3;
   localparam int PtrWidth  = 48;
   localparam int KindWidth = 2;
   localparam int LenWidth  = 6;
   localparam int CfgWidth  = 4;
   localparam int CsrAddrW  = 3;

   localparam logic [OpWidth-1:0] OP_PLACE   = 3'd0;
   localparam logic [OpWidth-1:0] OP_REPLACE = 3'd1;
   localparam logic [OpWidth-1:0] OP_LIST    = 3'd2;
   localparam logic [OpWidth-1:0] OP_TEMP    = 3'd3;
   localparam logic [OpWidth-1:0] OP_RELEASE = 3'd4;
   localparam logic [OpWidth-1:0] OP_RETIRE  = 3'd5;

   localparam logic [KindWidth-1:0] KIND_FREED    = 2'd0;
   localparam logic [KindWidth-1:0] KIND_DONE     = 2'd1;
   localparam logic [KindWidth-1:0] KIND_ACCEPTED = 2'd2;
   localparam logic [KindWidth-1:0] KIND_REFUSED  = 2'd3;

   localparam logic CSR_IDX_ACTIVE = 1'b0;
   localparam logic [CfgWidth-1:0] ACTIVE_RESET = 4'd8;

   typedef struct packed {
      logic capture;
      logic apply;
      logic scan_init;
      logic rd_issue;
      logic cmp_capture;
      logic keep;
      logic emit_freed;
      logic scan_done;
      logic emit_final;
   } hpre_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic remain_zero;
      logic hit;
      logic out_free;
   } hpre_sts_type;

endpackage

FILE: sv/hpre_req_if.sv
// Channel interfaces for the hazard pointer reclaim engine.
// Depends on hpre_pkg for the payload widths.
interface hpre_req_if;
   import hpre_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OpWidth-1:0]   operation;
   logic [TidWidth-1:0]  thread_index;
   logic [PtrWidth-1:0]  pointer_value;
   modport source (output valid, operation, thread_index, pointer_value, input ready);
   modport sink (input valid, operation, thread_index, pointer_value, output ready);
endinterface

interface hpre_rsp_if;
   import hpre_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] result_kind;
   logic [PtrWidth-1:0]  freed_pointer;
   logic [LenWidth-1:0]  retire_length;
   logic                 last_result;
   modport source (output valid, result_kind, freed_pointer, retire_length, last_result,
                   input ready);
   modport sink (input valid, result_kind, freed_pointer, retire_length, last_result,
                 output ready);
endinterface

FILE: sv/hpre_datapath.sv
// Datapath of the hazard pointer reclaim engine: hazard slots, retire list memory,
// scan compare, configuration register and result register. Depends on hpre_pkg.
module hpre_datapath #(
   parameter int MAX_THREADS      = 8,
   parameter int SLOTS_PER_THREAD = 4,
   parameter int LIST_SLOTS       = 2,
   parameter int RETIRE_DEPTH     = 32,
   parameter int POINTER_WIDTH    = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hpre_pkg::hpre_cmd_type             cmd,
   output hpre_pkg::hpre_sts_type             sts,
   input  logic [hpre_pkg::OpWidth-1:0]       req_operation,
   input  logic [hpre_pkg::TidWidth-1:0]      req_thread_index,
   input  logic [hpre_pkg::PtrWidth-1:0]      req_pointer_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [hpre_pkg::KindWidth-1:0]     rsp_result_kind,
   output logic [hpre_pkg::PtrWidth-1:0]      rsp_freed_pointer,
   output logic [hpre_pkg::LenWidth-1:0]      rsp_retire_length,
   output logic                               rsp_last_result,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hpre_pkg::CsrAddrW-1:0]      csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import hpre_pkg::*;

   localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int SW = (SLOTS_PER_THREAD > 1) ? $clog2(SLOTS_PER_THREAD) : 1;
   localparam int LW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
   localparam int IW = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
   localparam int CW = $clog2(RETIRE_DEPTH + 1);
   localparam int MemDepth = 2 << IW;
   localparam logic [PtrWidth-1:0] PtrMask = (POINTER_WIDTH >= PtrWidth) ? '1 :
      PtrWidth'((64'd1 << POINTER_WIDTH) - 64'd1);

   logic [OpWidth-1:0]  op_ff;
   logic [TidWidth-1:0] tid_ff;
   logic [PtrWidth-1:0] ptr_ff;
   logic [PtrWidth-1:0] hz_ff [MAX_THREADS][SLOTS_PER_THREAD];
   logic [PtrWidth-1:0] tmp_ff [MAX_THREADS];
   logic [SW-1:0]       ns_ff [MAX_THREADS];
   logic [SW-1:0]       pos_ff [MAX_THREADS];
   logic [LW-1:0]       lo_ff [MAX_THREADS];
   logic [CW-1:0]       count_ff, remain_ff, nkept_ff;
   logic                bank_ff, freed_any_ff, scanned_ff, hit_ff;
   logic [PtrWidth-1:0] mem [MemDepth];
   logic [PtrWidth-1:0] rdata_ff;
   logic [CfgWidth-1:0] active_ff;
   logic                rsp_valid_ff, last_ff;
   logic [KindWidth-1:0] kind_ff;
   logic [PtrWidth-1:0] fptr_ff;
   logic [LenWidth-1:0] len_ff;

   logic [TW-1:0]       tix;
   logic                tid_ok, is_retire, ptr_zero, list_full, out_free, hit_comb;
   logic                mem_we;
   logic [IW:0]         mem_waddr;
   logic [PtrWidth-1:0] mem_wdata;
   logic [CW-1:0]       remain_dec;

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] x);
      slot_inc = (x == SW'(SLOTS_PER_THREAD - 1)) ? '0 : x + SW'(1);
   endfunction

   function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] x);
      slot_dec = (x == '0) ? SW'(SLOTS_PER_THREAD - 1) : x - SW'(1);
   endfunction

   assign tix        = TW'(tid_ff);
   assign tid_ok     = 32'(tid_ff) < MAX_THREADS;
   assign is_retire  = op_ff == OP_RETIRE;
   assign ptr_zero   = ptr_ff == '0;
   assign list_full  = 32'(count_ff) >= RETIRE_DEPTH;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign remain_dec = remain_ff - CW'(1);

   assign sts.scan_needed = is_retire && !ptr_zero && list_full;
   assign sts.remain_zero = remain_ff == '0;
   assign sts.hit         = hit_ff;
   assign sts.out_free    = out_free;

   always_comb begin
      hit_comb = 1'b0;
      for (int t = 0; t < MAX_THREADS; t++) begin
         if (32'(active_ff) > t) begin
            for (int s = 0; s < SLOTS_PER_THREAD; s++) begin
               if (hz_ff[t][s] == rdata_ff) hit_comb = 1'b1;
            end
            if (tmp_ff[t] == rdata_ff) hit_comb = 1'b1;
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {bank_ff, count_ff[IW-1:0]};
      mem_wdata = ptr_ff;
      if (cmd.apply && is_retire && !ptr_zero && !list_full) begin
         mem_we = 1'b1;
      end else if (cmd.keep) begin
         mem_we    = 1'b1;
         mem_waddr = {~bank_ff, nkept_ff[IW-1:0]};
         mem_wdata = rdata_ff;
      end else if (cmd.scan_done && freed_any_ff) begin
         mem_we    = 1'b1;
         mem_waddr = {~bank_ff, nkept_ff[IW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.rd_issue) rdata_ff <= mem[{bank_ff, remain_dec[IW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         tid_ff <= req_thread_index;
         ptr_ff <= req_pointer_value & PtrMask;
      end
      if (cmd.cmp_capture) hit_ff <= hit_comb;
      if (cmd.scan_init) remain_ff <= count_ff;
      else if (cmd.rd_issue) remain_ff <= remain_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < MAX_THREADS; t++) begin
            for (int s = 0; s < SLOTS_PER_THREAD; s++) hz_ff[t][s] <= '0;
            tmp_ff[t] <= '0;
            ns_ff[t]  <= '0;
            pos_ff[t] <= '0;
            lo_ff[t]  <= '0;
         end
      end else if (cmd.apply && tid_ok) begin
         case (op_ff)
            OP_PLACE: begin
               hz_ff[tix][ns_ff[tix]] <= ptr_ff;
               ns_ff[tix]  <= slot_inc(ns_ff[tix]);
               pos_ff[tix] <= slot_inc(pos_ff[tix]);
            end
            OP_REPLACE: begin
               hz_ff[tix][slot_dec(ns_ff[tix])] <= ptr_ff;
            end
            OP_LIST: begin
               hz_ff[tix][pos_ff[tix]] <= ptr_ff;
               if (lo_ff[tix] == LW'(LIST_SLOTS - 1)) begin
                  lo_ff[tix]  <= '0;
                  pos_ff[tix] <= ns_ff[tix];
               end else begin
                  lo_ff[tix]  <= lo_ff[tix] + LW'(1);
                  pos_ff[tix] <= slot_inc(pos_ff[tix]);
               end
            end
            OP_TEMP: begin
               tmp_ff[tix] <= ptr_ff;
            end
            OP_RELEASE: begin
               for (int s = 0; s < SLOTS_PER_THREAD; s++) hz_ff[tix][s] <= '0;
               tmp_ff[tix] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         nkept_ff     <= '0;
         freed_any_ff <= 1'b0;
         scanned_ff   <= 1'b0;
      end else begin
         if (cmd.capture) scanned_ff <= 1'b0;
         if (cmd.apply && is_retire && !ptr_zero && !list_full) count_ff <= count_ff + CW'(1);
         if (cmd.scan_init) begin
            nkept_ff     <= '0;
            freed_any_ff <= 1'b0;
            scanned_ff   <= 1'b1;
         end
         if (cmd.keep) nkept_ff <= nkept_ff + CW'(1);
         if (cmd.emit_freed) freed_any_ff <= 1'b1;
         if (cmd.scan_done) begin
            count_ff <= nkept_ff + CW'(freed_any_ff);
            bank_ff  <= ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CsrAddrW-1] == CSR_IDX_ACTIVE) begin
         active_ff <= csr_pwdata[CfgWidth-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CsrAddrW-1] == CSR_IDX_ACTIVE) ? 32'(active_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_freed || cmd.emit_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_freed) begin
         kind_ff <= KIND_FREED;
         fptr_ff <= rdata_ff;
         len_ff  <= LenWidth'(remain_ff + nkept_ff);
         last_ff <= 1'b0;
      end else if (cmd.emit_final) begin
         if (!is_retire) kind_ff <= KIND_DONE;
         else if (scanned_ff && !freed_any_ff) kind_ff <= KIND_REFUSED;
         else kind_ff <= KIND_ACCEPTED;
         fptr_ff <= '0;
         len_ff  <= LenWidth'(count_ff);
         last_ff <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_freed_pointer = fptr_ff;
   assign rsp_retire_length = len_ff;
   assign rsp_last_result   = last_ff;

endmodule

FILE: sv/hpre_ctrl.sv
// Controller of the hazard pointer reclaim engine: sequences operations and retire scans.
// Depends on hpre_pkg for the command and status types.
module hpre_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output hpre_pkg::hpre_cmd_type cmd,
   input  hpre_pkg::hpre_sts_type sts
);
   import hpre_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_APPLY    = 6'b000010,
      ST_SCAN_RD  = 6'b000100,
      ST_SCAN_MEM = 6'b001000,
      ST_SCAN_ACT = 6'b010000,
      ST_FINAL    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (sts.scan_needed) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_SCAN_RD: begin
            if (sts.remain_zero) begin
               cmd.scan_done = 1'b1;
               state_in      = ST_FINAL;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_SCAN_MEM;
            end
         end
         ST_SCAN_MEM: begin
            cmd.cmp_capture = 1'b1;
            state_in        = ST_SCAN_ACT;
         end
         ST_SCAN_ACT: begin
            if (sts.hit) begin
               cmd.keep = 1'b1;
               state_in = ST_SCAN_RD;
            end else if (sts.out_free) begin
               cmd.emit_freed = 1'b1;
               state_in       = ST_SCAN_RD;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: sv/hazard_pointer_reclaim_engine_core.sv
// Top level of the hazard pointer reclaim engine.
// Depends on hpre_pkg, hpre_req_if, hpre_rsp_if, hpre_ctrl and hpre_datapath.

// One item is taken at a time. A slot operation, a retire into a list with room and a
// retire of null pass through the APPLY and FINAL states, and the result is written into
// the result register from FINAL once that register is free. A retire into a full list
// scans the list: one entry at a time, through the SCAN_RD, SCAN_MEM and SCAN_ACT states,
// the single read port of the retire list memory and the registered parallel compare
// against the hazard and temporary slots of the active threads; the result side can stall
// the scan. A result register lets the last result wait while the next item is taken.
module hazard_pointer_reclaim_engine_core #(
   parameter int MAX_THREADS      = 8,
   parameter int SLOTS_PER_THREAD = 4,
   parameter int LIST_SLOTS       = 2,
   parameter int RETIRE_DEPTH     = 32,
   parameter int POINTER_WIDTH    = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   hpre_req_if.sink                      req_chan,
   hpre_rsp_if.source                    rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hpre_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import hpre_pkg::*;

   hpre_cmd_type cmd;
   hpre_sts_type sts;

   hpre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   hpre_datapath #(
      .MAX_THREADS      (MAX_THREADS),
      .SLOTS_PER_THREAD (SLOTS_PER_THREAD),
      .LIST_SLOTS       (LIST_SLOTS),
      .RETIRE_DEPTH     (RETIRE_DEPTH),
      .POINTER_WIDTH    (POINTER_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_chan.operation),
      .req_thread_index  (req_chan.thread_index),
      .req_pointer_value (req_chan.pointer_value),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_result_kind   (rsp_chan.result_kind),
      .rsp_freed_pointer (rsp_chan.freed_pointer),
      .rsp_retire_length (rsp_chan.retire_length),
      .rsp_last_result   (rsp_chan.last_result),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> 32'(rsp_chan.retire_length) <= RETIRE_DEPTH)
      else $error("retire length beyond list depth");

   a_freed_nonnull: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_kind == KIND_FREED |->
      rsp_chan.freed_pointer != '0 && !rsp_chan.last_result)
      else $error("freed result with null pointer or marked last");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_kind != KIND_FREED |-> rsp_chan.last_result)
      else $error("closing result not marked last");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_freed && cmd.emit_final) && !(req_chan.ready && rsp_chan.valid &&
      rsp_chan.result_kind == KIND_FREED && !rsp_chan.ready && $past(cmd.emit_freed)))
      else $error("conflicting result commands");

endmodule
